[design/dbu_pkg.sv]
`default_nettype none
package dbu_pkg;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXEL,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      PK_BIT,
      PK_NIB,
      PK_BYTE,
      PK_RGB
   } pix_kind_type;

   localparam logic [1:0] KIND_INFO  = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] MODE_L       = 2'd0;
   localparam logic [1:0] MODE_BILEVEL = 2'd1;
   localparam logic [1:0] MODE_RGB     = 2'd2;

   localparam logic [3:0] ERR_SHORT_HEADER = 4'd1;
   localparam logic [3:0] ERR_HEADER_SIZE  = 4'd2;
   localparam logic [3:0] ERR_COMPRESSED   = 4'd3;
   localparam logic [3:0] ERR_WIDTH        = 4'd4;
   localparam logic [3:0] ERR_HEIGHT       = 4'd5;
   localparam logic [3:0] ERR_DEPTH        = 4'd6;
   localparam logic [3:0] ERR_PALETTE      = 4'd7;
   localparam logic [3:0] ERR_DATA_SHORT   = 4'd8;

   localparam logic [5:0] HEADER_LAST = 6'd39;
   localparam int unsigned JOB_DEPTH  = 4;

   // one input word's worth of results: optional info, 0..8 pixels, optional error
   typedef struct packed {
      logic         info_en;
      logic         info_end;
      logic [1:0]   info_mode;
      logic [14:0]  width;
      logic [14:0]  height;
      logic [3:0]   pix_n;
      pix_kind_type pix_kind;
      logic [14:0]  x0;
      logic [14:0]  y;
      logic [7:0]   data;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic         pix_end;
      logic         err_en;
      logic [3:0]   err_code;
   } job_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [14:0] pos_x;
      logic [14:0] pos_y;
      logic [7:0]  level_or_red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [1:0]  image_mode;
      logic [3:0]  error_code;
      logic        last_of_run;
      logic        image_end;
   } result_type;

endpackage
`default_nettype wire

[design/dbu_if.sv]
`default_nettype none
interface dbu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;
   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface dbu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [14:0] pos_x;
   logic [14:0] pos_y;
   logic [7:0]  level_or_red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [1:0]  image_mode;
   logic [3:0]  error_code;
   logic        last_of_run;
   logic        image_end;
   modport source (output valid, output kind, output pos_x, output pos_y,
                   output level_or_red, output green, output blue, output image_mode,
                   output error_code, output last_of_run, output image_end,
                   input ready);
   modport sink (input valid, input kind, input pos_x, input pos_y,
                 input level_or_red, input green, input blue, input image_mode,
                 input error_code, input last_of_run, input image_end,
                 output ready);
endinterface
`default_nettype wire

[design/dib_bitmap_unpacker_top.sv]
// Bitmap unpacker: streams an uncompressed device-independent bitmap in, one
// byte per req_chan word (final_byte marks the buffer's last byte), and
// gives pixel, info and error words on rsp_chan.
// Front end parses the 40-byte header, skips extra header and palette bytes,
// tracks row/column and turns each byte into a job of up to eight results;
// a four-entry job queue decouples it from the back end, which issues one
// result word per cycle, while the receiver is ready, into a registered output stage.
// The first result of a byte reaches rsp_chan by way of the queue write,
// the job load and the output register.
// Throughput: one byte per cycle while bytes give at most one result each
// and the receiver is ready; 1 bpp bytes give up to eight pixels, so there
// the result port (one word per cycle) sets the rate.
// Receiver stall: the output stage holds, the queue fills and req_chan.ready
// drops once four jobs are waiting.
// Reset (synchronous, active high) returns the parser to the header phase and
// empties queue and output stage.
`default_nettype none
module dib_bitmap_unpacker_top import dbu_pkg::*; #(
   parameter int unsigned MAX_SIDE = 32767
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dbu_req_if.sink    req_chan,
   dbu_rsp_if.source  rsp_chan
);

   job_type  push_job, head_job;
   logic     push, pop, full, empty;

   // byte parser and classifier
   dbu_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .job_full (full),
      .job_push (push),
      .job      (push_job)
   );

   // jobs waiting for the result side
   dbu_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head_job),
      .full     (full),
      .empty    (empty)
   );

   // result expansion, one word per cycle while the receiver is ready
   dbu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_valid (!empty),
      .job_pop   (pop),
      .rsp       (rsp_chan)
   );

endmodule
`default_nettype wire

[design/dbu_front.sv]
`default_nettype none
module dbu_front import dbu_pkg::*; #(
   parameter int unsigned MAX_SIDE = 32767
) (
   input  wire logic    clock,
   input  wire logic    reset,
   dbu_req_if.sink      req,
   input  wire logic    job_full,
   output logic         job_push,
   output job_type      job
);

   phase_type    phase_ff, phase_in;
   logic [5:0]   off_ff, off_in;
   logic [31:0]  hsize_ff, hsize_in, width_ff, width_in, rawh_ff, rawh_in;
   logic [15:0]  bpp_ff, bpp_in;
   logic [31:0]  comp_ff, comp_in, cused_ff, cused_in;
   logic [34:0]  skip_ff, skip_in;
   logic [14:0]  absh_ff, absh_in;
   logic         topdown_ff, topdown_in;
   logic [16:0]  stride_ff, stride_in, needed_ff, needed_in;
   logic [16:0]  bir_ff, bir_in;
   logic [14:0]  row_ff, row_in;
   logic [15:0]  gath_ff, gath_in;
   logic [1:0]   gcnt_ff, gcnt_in;
   logic [14:0]  px_ff, px_in;

   logic         accept, fin;
   logic         ev_done, ev_skip, ev_pixel, do_after;
   logic [31:0]  absh32, pal;
   logic [34:0]  skip_init;
   logic         c_hs, c_comp, c_w, c_h, empty_img, bpp_ok;
   logic [1:0]   mode_calc;
   logic [14:0]  w15;
   logic [20:0]  bits;
   logic [21:0]  bits_up;
   logic [16:0]  stride_calc, needed_calc;
   logic [14:0]  ycalc;
   logic         last_row, ends, b_lt;
   logic [15:0]  rem1;
   logic [17:0]  bir_next;

   assign accept = req.valid && req.ready;
   assign fin    = req.final_byte;
   assign req.ready = !job_full;

   // header checks, all from registered fields
   assign absh32    = rawh_ff[31] ? (~rawh_ff + 32'd1) : rawh_ff;
   assign c_hs      = hsize_ff < 32'd40;
   assign c_comp    = comp_ff != 32'd0;
   assign c_w       = width_ff > 32'(MAX_SIDE);
   assign c_h       = absh32 > 32'(MAX_SIDE);
   assign empty_img = (width_ff == 32'd0) || (absh32 == 32'd0);
   assign bpp_ok    = (bpp_ff == 16'd1) || (bpp_ff == 16'd4) || (bpp_ff == 16'd8) ||
                      (bpp_ff == 16'd24) || (bpp_ff == 16'd32);
   assign mode_calc = (bpp_ff == 16'd24 || bpp_ff == 16'd32) ? MODE_RGB :
                      (bpp_ff == 16'd1) ? MODE_BILEVEL : MODE_L;
   assign pal       = (bpp_ff > 16'd8) ? 32'd0 :
                      (cused_ff != 32'd0) ? cused_ff : (32'd1 << bpp_ff[3:0]);
   assign skip_init = 35'(hsize_ff - 32'd40) + 35'({pal, 2'b00});

   assign w15 = width_ff[14:0];
   always_comb begin
      case (bpp_ff)
         16'd1:   begin bits = {6'b0, w15};
                        needed_calc = 17'(({2'b0, w15} + 17'd7) >> 3); end
         16'd4:   begin bits = {4'b0, w15, 2'b0};
                        needed_calc = 17'(({2'b0, w15} + 17'd1) >> 1); end
         16'd8:   begin bits = {3'b0, w15, 3'b0};
                        needed_calc = {2'b0, w15}; end
         16'd24:  begin bits = 21'({w15, 4'b0}) + 21'({w15, 3'b0});
                        needed_calc = {2'b0, w15} + {1'b0, w15, 1'b0}; end
         default: begin bits = {1'b0, w15, 5'b0};
                        needed_calc = {w15, 2'b0} - 17'd1; end
      endcase
   end
   assign bits_up     = {1'b0, bits} + 22'd31;
   assign stride_calc = {bits_up[19:5], 2'b00};

   // pixel-phase position
   assign ycalc    = topdown_ff ? row_ff : (absh_ff - 15'd1 - row_ff);
   assign last_row = ({1'b0, row_ff} + 16'd1) == {1'b0, absh_ff};
   assign bir_next = {1'b0, bir_ff} + 18'd1;
   assign ends     = last_row && (bir_next == {1'b0, needed_ff});
   assign b_lt     = bir_ff < needed_ff;
   assign rem1     = {1'b0, w15} - {1'b0, bir_ff[11:0], 3'b000};

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (fin)
            phase_in = PH_HEADER;
         else if (ev_done)
            phase_in = PH_DONE;
         else if (ev_pixel)
            phase_in = PH_PIXEL;
         else if (ev_skip)
            phase_in = PH_SKIP;
      end
   end

   always_comb begin
      off_in = off_ff; hsize_in = hsize_ff; width_in = width_ff; rawh_in = rawh_ff;
      bpp_in = bpp_ff; comp_in = comp_ff; cused_in = cused_ff; skip_in = skip_ff;
      absh_in = absh_ff; topdown_in = topdown_ff; stride_in = stride_ff;
      needed_in = needed_ff; bir_in = bir_ff; row_in = row_ff; gath_in = gath_ff;
      gcnt_in = gcnt_ff; px_in = px_ff;
      job = '0;
      ev_done = 1'b0; ev_skip = 1'b0; ev_pixel = 1'b0; do_after = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               off_in = off_ff + 6'd1;
               if (off_ff < 6'd4)
                  hsize_in[8*off_ff[1:0] +: 8] = req.data_byte;
               else if (off_ff < 6'd8)
                  width_in[8*off_ff[1:0] +: 8] = req.data_byte;
               else if (off_ff < 6'd12)
                  rawh_in[8*off_ff[1:0] +: 8] = req.data_byte;
               else if (off_ff == 6'd14 || off_ff == 6'd15)
                  bpp_in[8*off_ff[0] +: 8] = req.data_byte;
               else if (off_ff >= 6'd16 && off_ff < 6'd20)
                  comp_in[8*off_ff[1:0] +: 8] = req.data_byte;
               else if (off_ff >= 6'd32 && off_ff < 6'd36)
                  cused_in[8*off_ff[1:0] +: 8] = req.data_byte;
               if (off_ff == HEADER_LAST) begin
                  if (c_hs) begin
                     job.err_en = 1'b1; job.err_code = ERR_HEADER_SIZE; ev_done = 1'b1;
                  end else if (c_comp) begin
                     job.err_en = 1'b1; job.err_code = ERR_COMPRESSED; ev_done = 1'b1;
                  end else if (c_w) begin
                     job.err_en = 1'b1; job.err_code = ERR_WIDTH; ev_done = 1'b1;
                  end else if (c_h) begin
                     job.err_en = 1'b1; job.err_code = ERR_HEIGHT; ev_done = 1'b1;
                  end else if (empty_img) begin
                     job.info_en = 1'b1; job.info_end = 1'b1; job.info_mode = mode_calc;
                     job.width = w15; job.height = absh32[14:0]; ev_done = 1'b1;
                  end else begin
                     absh_in = absh32[14:0];
                     topdown_in = rawh_ff[31];
                     if (skip_init == 35'd0)
                        do_after = 1'b1;
                     else begin
                        skip_in = skip_init;
                        ev_skip = 1'b1;
                        if (fin) begin
                           job.err_en = 1'b1; job.err_code = ERR_PALETTE; ev_done = 1'b1;
                        end
                     end
                  end
               end else if (fin) begin
                  job.err_en = 1'b1; job.err_code = ERR_SHORT_HEADER; ev_done = 1'b1;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 35'd1;
               if (skip_in == 35'd0)
                  do_after = 1'b1;
               else if (fin) begin
                  job.err_en = 1'b1; job.err_code = ERR_PALETTE; ev_done = 1'b1;
               end
            end
            PH_PIXEL: begin
               if (fin && !ends) begin
                  job.err_en = 1'b1; job.err_code = ERR_DATA_SHORT; ev_done = 1'b1;
               end else begin
                  job.y = ycalc;
                  job.data = req.data_byte;
                  if (b_lt) begin
                     case (bpp_ff)
                        16'd1: begin
                           job.pix_kind = PK_BIT;
                           job.x0 = {bir_ff[11:0], 3'b000};
                           job.pix_n = (rem1 >= 16'd8) ? 4'd8 : rem1[3:0];
                        end
                        16'd4: begin
                           job.pix_kind = PK_NIB;
                           job.x0 = {bir_ff[13:0], 1'b0};
                           job.pix_n = ({1'b0, bir_ff[13:0], 1'b1} < {1'b0, w15}) ?
                                       4'd2 : 4'd1;
                        end
                        16'd8: begin
                           job.pix_kind = PK_BYTE;
                           job.x0 = bir_ff[14:0];
                           job.pix_n = 4'd1;
                        end
                        16'd24: begin
                           job.pix_kind = PK_RGB;
                           job.x0 = px_ff;
                           job.green = gath_ff[15:8];
                           job.blue = gath_ff[7:0];
                           if (gcnt_ff == 2'd2) begin
                              job.pix_n = 4'd1;
                              px_in = px_ff + 15'd1;
                              gath_in = '0;
                              gcnt_in = 2'd0;
                           end else begin
                              gath_in[8*gcnt_ff[0] +: 8] = req.data_byte;
                              gcnt_in = gcnt_ff + 2'd1;
                           end
                        end
                        default: begin
                           job.pix_kind = PK_RGB;
                           job.x0 = bir_ff[16:2];
                           job.green = gath_ff[15:8];
                           job.blue = gath_ff[7:0];
                           if (bir_ff[1:0] == 2'd2) begin
                              job.pix_n = 4'd1;
                              gath_in = '0;
                           end else if (bir_ff[1:0] < 2'd2)
                              gath_in[8*bir_ff[0] +: 8] = req.data_byte;
                        end
                     endcase
                  end
                  if (ends) begin
                     job.pix_end = 1'b1;
                     ev_done = 1'b1;
                  end else if (bir_next >= {1'b0, stride_ff}) begin
                     bir_in = '0; row_in = row_ff + 15'd1;
                     gath_in = '0; gcnt_in = 2'd0; px_in = '0;
                  end else
                     bir_in = bir_next[16:0];
               end
            end
            default: ;
         endcase
         if (do_after) begin
            if (!bpp_ok) begin
               job.err_en = 1'b1; job.err_code = ERR_DEPTH; ev_done = 1'b1;
            end else begin
               job.info_en = 1'b1; job.info_mode = mode_calc;
               job.width = w15; job.height = absh32[14:0];
               stride_in = stride_calc; needed_in = needed_calc;
               bir_in = '0; row_in = '0; gath_in = '0; gcnt_in = 2'd0; px_in = '0;
               ev_pixel = 1'b1;
               if (fin) begin
                  job.err_en = 1'b1; job.err_code = ERR_DATA_SHORT; ev_done = 1'b1;
               end
            end
         end
         if (fin) begin
            off_in = '0; hsize_in = '0; width_in = '0; rawh_in = '0; bpp_in = '0;
            comp_in = '0; cused_in = '0; skip_in = '0; absh_in = '0; topdown_in = 1'b0;
            stride_in = '0; needed_in = '0; bir_in = '0; row_in = '0; gath_in = '0;
            gcnt_in = 2'd0; px_in = '0;
         end
      end
   end

   assign job_push = accept && (job.info_en || job.err_en || (job.pix_n != 4'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         off_ff <= '0; hsize_ff <= '0; width_ff <= '0; rawh_ff <= '0; bpp_ff <= '0;
         comp_ff <= '0; cused_ff <= '0; skip_ff <= '0; absh_ff <= '0; topdown_ff <= 1'b0;
         stride_ff <= '0; needed_ff <= '0; bir_ff <= '0; row_ff <= '0; gath_ff <= '0;
         gcnt_ff <= '0; px_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         off_ff <= off_in; hsize_ff <= hsize_in; width_ff <= width_in; rawh_ff <= rawh_in;
         bpp_ff <= bpp_in; comp_ff <= comp_in; cused_ff <= cused_in; skip_ff <= skip_in;
         absh_ff <= absh_in; topdown_ff <= topdown_in; stride_ff <= stride_in;
         needed_ff <= needed_in; bir_ff <= bir_in; row_ff <= row_in; gath_ff <= gath_in;
         gcnt_ff <= gcnt_in; px_ff <= px_in;
      end
   end

endmodule
`default_nettype wire

[design/dbu_job_queue.sv]
`default_nettype none
module dbu_job_queue import dbu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head,
   output logic         full,
   output logic         empty
);

   localparam int unsigned PW = $clog2(JOB_DEPTH);

   job_type         mem_ff [JOB_DEPTH];
   logic [PW-1:0]   wptr_ff, rptr_ff;
   logic [PW:0]     cnt_ff;
   logic            do_push, do_pop;

   assign full    = cnt_ff == (PW+1)'(JOB_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (do_push)
            wptr_ff <= wptr_ff + PW'(1);
         if (do_pop)
            rptr_ff <= rptr_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(JOB_DEPTH)) else $error("job queue over depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("job popped from empty queue");
`endif

endmodule
`default_nettype wire

[design/dbu_back.sv]
`default_nettype none
module dbu_back import dbu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type job,
   input  wire logic    job_valid,
   output logic         job_pop,
   dbu_rsp_if.source    rsp
);

   job_type     cur_ff, cur_in;
   logic        active_ff, active_in, ipend_ff, ipend_in, epend_ff, epend_in;
   logic [3:0]  idx_ff, idx_in;
   logic        oval_ff, oval_in;
   result_type  res_ff, res_in;
   result_type  sel;
   logic        adv, is_last, pix_pend, pix_last;

   assign adv      = active_ff && (!oval_ff || rsp.ready);
   assign pix_pend = idx_ff < cur_ff.pix_n;
   assign pix_last = (idx_ff + 4'd1) == cur_ff.pix_n;

   always_comb begin
      sel = '0;
      is_last = 1'b0;
      if (ipend_ff) begin
         sel.kind = KIND_INFO;
         sel.pos_x = cur_ff.width;
         sel.pos_y = cur_ff.height;
         sel.image_mode = cur_ff.info_mode;
         sel.image_end = cur_ff.info_end;
         is_last = (cur_ff.pix_n == 4'd0) && !epend_ff;
      end else if (pix_pend) begin
         sel.kind = KIND_PIXEL;
         sel.pos_x = cur_ff.x0 + 15'(idx_ff);
         sel.pos_y = cur_ff.y;
         sel.image_end = cur_ff.pix_end && pix_last;
         case (cur_ff.pix_kind)
            PK_BIT: begin
               sel.level_or_red = cur_ff.data[3'd7 - idx_ff[2:0]] ? 8'd255 : 8'd0;
               sel.image_mode = MODE_BILEVEL;
            end
            PK_NIB: begin
               sel.level_or_red = {4'd0, idx_ff[0] ? cur_ff.data[3:0] : cur_ff.data[7:4]};
               sel.image_mode = MODE_L;
            end
            PK_BYTE: begin
               sel.level_or_red = cur_ff.data;
               sel.image_mode = MODE_L;
            end
            default: begin
               sel.level_or_red = cur_ff.data;
               sel.green = cur_ff.green;
               sel.blue = cur_ff.blue;
               sel.image_mode = MODE_RGB;
            end
         endcase
         is_last = pix_last && !epend_ff;
      end else begin
         sel.kind = KIND_ERROR;
         sel.error_code = cur_ff.err_code;
         sel.image_end = 1'b1;
         is_last = 1'b1;
      end
      sel.last_of_run = is_last;
   end

   assign job_pop = job_valid && (!active_ff || (adv && is_last));

   always_comb begin
      cur_in = cur_ff; active_in = active_ff; ipend_in = ipend_ff; epend_in = epend_ff;
      idx_in = idx_ff; oval_in = oval_ff; res_in = res_ff;
      if (adv) begin
         res_in = sel;
         oval_in = 1'b1;
         if (ipend_ff)
            ipend_in = 1'b0;
         else if (pix_pend)
            idx_in = idx_ff + 4'd1;
         else
            epend_in = 1'b0;
         if (is_last)
            active_in = 1'b0;
      end else if (rsp.ready)
         oval_in = 1'b0;
      if (job_pop) begin
         cur_in = job;
         active_in = 1'b1;
         ipend_in = job.info_en;
         epend_in = job.err_en;
         idx_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ipend_ff <= 1'b0;
         epend_ff <= 1'b0;
         idx_ff <= '0;
         oval_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         ipend_ff <= ipend_in;
         epend_ff <= epend_in;
         idx_ff <= idx_in;
         oval_ff <= oval_in;
      end
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   assign rsp.valid        = oval_ff;
   assign rsp.kind         = res_ff.kind;
   assign rsp.pos_x        = res_ff.pos_x;
   assign rsp.pos_y        = res_ff.pos_y;
   assign rsp.level_or_red = res_ff.level_or_red;
   assign rsp.green        = res_ff.green;
   assign rsp.blue         = res_ff.blue;
   assign rsp.image_mode   = res_ff.image_mode;
   assign rsp.error_code   = res_ff.error_code;
   assign rsp.last_of_run  = res_ff.last_of_run;
   assign rsp.image_end    = res_ff.image_end;

`ifndef SYNTHESIS
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      oval_ff |-> (res_ff.kind != 2'd3)) else $error("illegal result kind");
   a_active_has_work: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !ipend_ff && !epend_ff) |-> pix_pend)
      else $error("active job with nothing left");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (oval_ff && res_ff.image_end) |-> res_ff.last_of_run)
      else $error("image end not last of run");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
   import dbu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_SIDE_TB = 32767;

   logic clock;
   logic reset;

   dbu_req_if req_chan ();
   dbu_rsp_if rsp_chan ();

   dib_bitmap_unpacker_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // one byte of the bitmap stream; hold makes the sender wait until all
   // outstanding results are back before this word goes out
   typedef struct {
      logic [7:0] data;
      logic       fin;
      logic       hold;
   } byte_item_type;

   byte_item_type byte_q[$];
   result_type  pixel_q[$];   // results still owed by the unpacker
   int unsigned errors;
   int unsigned cyc;
   int unsigned send_gap;
   int unsigned rsp_stall;

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the parser and unpack counters
   // ---------------------------------------------------------------------
   phase_type         dec_phase;
   int unsigned       hdr_off, hdr_len, img_w, raw_h, depth, comp, ncolours;
   int unsigned       srow, bir, gather, gcount;
   longint unsigned   skip_cnt;
   int unsigned       abs_h, stride, needed;
   logic [1:0]        pmode;
   bit                rows_down;
   int                nres;

   function automatic void dec_clear();
      hdr_off = 0; hdr_len = 0; img_w = 0; raw_h = 0; depth = 0; comp = 0;
      ncolours = 0; srow = 0; bir = 0; gather = 0; gcount = 0;
      dec_phase = PH_HEADER; skip_cnt = 0; abs_h = 0; rows_down = 0;
      stride = 0; needed = 0; pmode = MODE_L;
   endfunction

   function automatic void push_result(logic [1:0] kind, int unsigned x, int unsigned y,
                                       int unsigned r, int unsigned g, int unsigned b,
                                       logic [1:0] mode, logic [3:0] err, bit img_end);
      result_type rr;
      if (nres >= 8) return;
      rr.kind = kind;
      rr.pos_x = x[14:0];
      rr.pos_y = y[14:0];
      rr.level_or_red = r[7:0];
      rr.green = g[7:0];
      rr.blue = b[7:0];
      rr.image_mode = mode;
      rr.error_code = err;
      rr.last_of_run = 1'b0;
      rr.image_end = img_end;
      pixel_q.push_back(rr);
      nres++;
   endfunction

   function automatic void raise_error(logic [3:0] code);
      push_result(KIND_ERROR, 0, 0, 0, 0, 0, MODE_L, code, 1'b1);
      dec_phase = PH_DONE;
   endfunction

   function automatic void start_pixels(bit fin);
      case (depth)
         1:  begin pmode = MODE_BILEVEL; needed = (img_w + 7) / 8; end
         4:  begin pmode = MODE_L; needed = (img_w + 1) / 2; end
         8:  begin pmode = MODE_L; needed = img_w; end
         24: begin pmode = MODE_RGB; needed = 3 * img_w; end
         32: begin pmode = MODE_RGB; needed = 4 * img_w - 1; end
         default: begin raise_error(ERR_DEPTH); return; end
      endcase
      stride = ((img_w * depth + 31) / 32) * 4;
      push_result(KIND_INFO, img_w, abs_h, 0, 0, 0, pmode, 4'd0, 1'b0);
      dec_phase = PH_PIXEL;
      srow = 0; bir = 0; gather = 0; gcount = 0;
      if (fin) raise_error(ERR_DATA_SHORT);
   endfunction

   function automatic void close_header(bit fin);
      int unsigned pal;
      logic [1:0]  m;
      if (hdr_len < 40) begin raise_error(ERR_HEADER_SIZE); return; end
      if (comp != 0) begin raise_error(ERR_COMPRESSED); return; end
      if (img_w > MAX_SIDE_TB) begin raise_error(ERR_WIDTH); return; end
      rows_down = raw_h[31];
      abs_h = rows_down ? (~raw_h + 1) : raw_h;
      if (abs_h > MAX_SIDE_TB) begin raise_error(ERR_HEIGHT); return; end
      if (img_w == 0 || abs_h == 0) begin
         m = (depth == 24 || depth == 32) ? MODE_RGB : (depth == 1 ? MODE_BILEVEL : MODE_L);
         push_result(KIND_INFO, img_w, abs_h, 0, 0, 0, m, 4'd0, 1'b1);
         dec_phase = PH_DONE;
         return;
      end
      pal = 0;
      if (depth <= 8) pal = (ncolours != 0) ? ncolours : (1 << depth);
      skip_cnt = longint'(hdr_len - 40) + longint'(pal) * 4;
      if (skip_cnt == 0) begin start_pixels(fin); return; end
      dec_phase = PH_SKIP;
      if (fin) raise_error(ERR_PALETTE);
   endfunction

   function automatic void header_word(int unsigned d, bit fin);
      int unsigned o = hdr_off;
      if (o < 4) hdr_len |= d << (8 * (o & 3));
      else if (o < 8) img_w |= d << (8 * ((o - 4) & 3));
      else if (o < 12) raw_h |= d << (8 * ((o - 8) & 3));
      else if (o == 14 || o == 15) depth |= d << (8 * ((o - 14) & 3));
      else if (o >= 16 && o < 20) comp |= d << (8 * ((o - 16) & 3));
      else if (o >= 32 && o < 36) ncolours |= d << (8 * ((o - 32) & 3));
      hdr_off = o + 1;
      if (hdr_off == 40) close_header(fin);
      else if (fin) raise_error(ERR_SHORT_HEADER);
   endfunction

   function automatic void pixel_word(int unsigned d, bit fin);
      int unsigned b = bir, x, k, y;
      bit last_row, ends;
      int first;
      y = rows_down ? srow : (abs_h - 1 - srow);
      last_row = (srow + 1 == abs_h);
      ends = last_row && (b + 1 == needed);
      first = nres;
      if (fin && !ends) begin raise_error(ERR_DATA_SHORT); return; end
      if (b < needed) begin
         if (depth == 1) begin
            for (k = 0; k < 8; k++) begin
               x = 8 * b + k;
               if (x < img_w)
                  push_result(KIND_PIXEL, x, y, ((d >> (7 - k)) & 1) ? 255 : 0, 0, 0,
                              MODE_BILEVEL, 4'd0, 1'b0);
            end
         end else if (depth == 4) begin
            x = 2 * b;
            push_result(KIND_PIXEL, x, y, d >> 4, 0, 0, MODE_L, 4'd0, 1'b0);
            if (x + 1 < img_w)
               push_result(KIND_PIXEL, x + 1, y, d & 'h0F, 0, 0, MODE_L, 4'd0, 1'b0);
         end else if (depth == 8) begin
            push_result(KIND_PIXEL, b, y, d, 0, 0, MODE_L, 4'd0, 1'b0);
         end else if (depth == 24) begin
            if (gcount == 2) begin
               push_result(KIND_PIXEL, b / 3, y, d, (gather >> 8) & 255, gather & 255,
                           MODE_RGB, 4'd0, 1'b0);
               gather = 0; gcount = 0;
            end else begin
               gather |= d << (8 * gcount);
               gcount++;
            end
         end else begin
            k = b & 3;
            if (k == 2) begin
               push_result(KIND_PIXEL, b >> 2, y, d, (gather >> 8) & 255, gather & 255,
                           MODE_RGB, 4'd0, 1'b0);
               gather = 0;
            end else if (k < 2) begin
               gather |= d << (8 * k);
            end
         end
      end
      if (ends) begin
         if (nres > first) pixel_q[$].image_end = 1'b1;
         dec_phase = PH_DONE;
         return;
      end
      b++;
      if (b >= stride) begin
         b = 0; srow++; gather = 0; gcount = 0;
      end
      bir = b;
   endfunction

   // expected results of one accepted byte
   function automatic void predict_byte(logic [7:0] d, logic fin);
      nres = 0;
      case (dec_phase)
         PH_HEADER: header_word(d, fin);
         PH_SKIP: begin
            skip_cnt--;
            if (skip_cnt == 0) start_pixels(fin);
            else if (fin) raise_error(ERR_PALETTE);
         end
         PH_PIXEL: pixel_word(d, fin);
         default: ;
      endcase
      if (fin) dec_clear();
      if (nres > 0) pixel_q[$].last_of_run = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   task automatic add_word(logic [7:0] d, bit fin, bit hold);
      byte_item_type it;
      it.data = d; it.fin = fin; it.hold = hold;
      byte_q.push_back(it);
   endtask

   // bitmap, cut short for large images; cut > 0 ends the buffer after that many bytes
   task automatic add_bitmap(int unsigned hlen, int unsigned w, int unsigned h,
                             int unsigned bpp, int unsigned cmp, int unsigned ncol,
                             int unsigned cut, bit fill_ones);
      logic [7:0] hdr[40];
      int unsigned total, pal, ah, str;
      int unsigned n, i;
      for (i = 0; i < 40; i++) hdr[i] = 8'($urandom_range(0, 255));  // unused fields random
      for (i = 0; i < 4; i++) begin
         hdr[i] = 8'(hlen >> (8 * i));
         hdr[4 + i] = 8'(w >> (8 * i));
         hdr[8 + i] = 8'(h >> (8 * i));
         hdr[16 + i] = 8'(cmp >> (8 * i));
         hdr[32 + i] = 8'(ncol >> (8 * i));
      end
      hdr[14] = 8'(bpp); hdr[15] = 8'(bpp >> 8);
      ah = h[31] ? (~h + 1) : h;
      if (hlen < 40 || cmp != 0 || w > MAX_SIDE_TB || ah > MAX_SIDE_TB) begin
         total = 43;
      end else begin
         pal = (bpp <= 8) ? ((ncol != 0) ? ncol : (1 << bpp)) : 0;
         str = ((w * bpp + 31) / 32) * 4;
         total = hlen + pal * 4 + ((w * ah > 4096) ? 8 : str * ah);
      end
      if (cut > 0) total = cut;
      for (n = 0; n < total; n++)
         add_word(n < 40 ? hdr[n] : (fill_ones ? 8'hFF : 8'($urandom_range(0, 255))),
                  n == total - 1, n == 0);
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset and stimulus plan
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      int i, n;
      reset = 1'b1;
      dec_clear();
      add_bitmap(40, 3, 2, 8, 0, 1, 6, 1'b0);              // short header
      add_bitmap(40, 9, 32'hFFFF_FFFE, 1, 0, 2, 0, 1'b0);  // bilevel top-down
      add_bitmap(44, 2, 1, 24, 0, 0, 0, 1'b0);             // extra header, RGB
      // noise: random bytes, then a buffer end
      for (i = 0; i < 2; i++) begin
         n = $urandom_range(5, 9);
         repeat (n) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         add_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Driver: sends queued bytes with random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.data_byte <= 8'd0;
         req_chan.final_byte <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_byte(req_chan.data_byte, req_chan.final_byte);
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap--;
            end else if (byte_q.size() > 0 && !(byte_q[0].hold && pixel_q.size() > 0)) begin
               req_chan.valid <= 1'b1;
               req_chan.data_byte <= byte_q[0].data;
               req_chan.final_byte <= byte_q[0].fin;
               void'(byte_q.pop_front());
               // stretches with no gaps in every third window of the cycle count
               send_gap = ((cyc / 400) % 3 == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure, checks each result word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind = rsp_chan.kind;
            got.pos_x = rsp_chan.pos_x;
            got.pos_y = rsp_chan.pos_y;
            got.level_or_red = rsp_chan.level_or_red;
            got.green = rsp_chan.green;
            got.blue = rsp_chan.blue;
            got.image_mode = rsp_chan.image_mode;
            got.error_code = rsp_chan.error_code;
            got.last_of_run = rsp_chan.last_of_run;
            got.image_end = rsp_chan.image_end;
            if (pixel_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, actual %p", $realtime, got);
            end else begin
               want = pixel_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch, expected %p actual %p", $realtime, want, got);
               end
            end
            rsp_stall = ((cyc / 400) % 3 == 1) ? 0 : $urandom_range(0, 6);
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // End of run
   // ---------------------------------------------------------------------
   initial begin
      cyc = 0;
      errors = 0;
      @(negedge reset);
      wait (byte_q.size() == 0 && !req_chan.valid);
      wait (pixel_q.size() == 0);
      repeat (30) @(posedge clock);
      if (errors == 0 && pixel_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (pixel_q.size() > 0)
            $display("%0t: %0d expected words never came", $realtime, pixel_q.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
